>>> rtl/frd_pkg.sv
`timescale 1ns / 1ps

package frd_pkg;

    localparam int TIME_BITS_DEFAULT = 31;
    localparam int RATE_BITS         = 10;
    localparam int PERIOD_BITS       = 10;
    localparam int DIVISOR_BITS      = RATE_BITS + 1;
    localparam int PERIOD_NUMER_BITS = 12;
    localparam int COUNT_BITS        = 32;
    localparam int STATUS_BITS       = 2;
    localparam int CFG_INDEX_BITS    = 1;
    localparam int MS_PER_SECOND     = 1000;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK               = 2'd0,
        STATUS_END_BEFORE_START = 2'd1,
        STATUS_START_GAP        = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_RATE     = 1'd0,
        CFG_DURATION_LIMIT = 1'd1
    } cfg_index_t;

endpackage

>>> rtl/frd_divider.sv
`timescale 1ns / 1ps

module frd_divider #(
    parameter int DIVIDEND_W = frd_pkg::TIME_BITS_DEFAULT,
    parameter int DIVISOR_W  = frd_pkg::DIVISOR_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_BITS = $clog2(DIVIDEND_W + 1);

    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  done_reg, done_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [DIVISOR_W:0]    trial;
    logic                  ge;

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        ge         = (trial >= {1'b0, div_reg});
        count_next = count_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start)
        begin
            count_next = CNT_BITS'(DIVIDEND_W);
            quo_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - CNT_BITS'(1);
            quo_next   = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next   = ge ? DIVISOR_W'(trial - {1'b0, div_reg}) : trial[DIVISOR_W-1:0];
            done_next  = (count_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/frame_rate_decimator_timing.sv
// Frame rate decimator, timing path.
// Input channel (in_valid / in_stall) carries frame_start and frame_end in ms;
// a transfer happens on a clock edge with valid high and stall low. Every input
// frame gives exactly one result on the output channel (out_valid / out_stall):
// status, keep decision, aligned output interval, stop flag, counters and the
// export duration so far.
// Configuration: cfg_write with cfg_index 0 (frame rate) or 1 (duration
// limit) and cfg_data, taken on the same edge. A frame rate write starts the
// period division on the shared bit-serial divider; in_stall is high meanwhile.
// A dropped frame, an error or rate 0 goes from the check state straight to
// the align and finish states; a kept frame that needs period alignment waits
// in the divide state between check and align, where the divider retires one
// quotient bit per cycle. The finish state loads the result once the output
// register is free; the block then returns to idle and takes the next frame.
// One output register parts the channels: a new frame is taken while a result
// waits; if the receiver still stalls when the next result is ready, the block
// holds it and keeps in_stall high.
// Reset clears rate, limit, cursor, consumed time and both counters.
`timescale 1ns / 1ps

module frame_rate_decimator_timing #(
    parameter int TIME_BITS = frd_pkg::TIME_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [frd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]              cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [TIME_BITS-1:0]              frame_start,
    input  logic [TIME_BITS-1:0]              frame_end,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [frd_pkg::STATUS_BITS-1:0]   status,
    output logic                              keep,
    output logic [TIME_BITS-1:0]              emit_start,
    output logic [TIME_BITS-1:0]              emit_end,
    output logic                              stop,
    output logic [frd_pkg::COUNT_BITS-1:0]    frames_seen,
    output logic [frd_pkg::COUNT_BITS-1:0]    frames_kept,
    output logic [TIME_BITS-1:0]              export_duration
);

    import frd_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PERIOD,
        S_CHECK,
        S_DIV,
        S_ALIGN,
        S_FINISH
    } state_t;

    state_t                 state_reg;
    logic [RATE_BITS-1:0]   rate_reg;
    logic [TIME_BITS-1:0]   limit_reg;
    logic [PERIOD_BITS-1:0] period_reg;
    logic [TIME_BITS-1:0]   cursor_reg;
    logic [TIME_BITS-1:0]   consumed_reg;
    logic [COUNT_BITS-1:0]  seen_reg;
    logic [COUNT_BITS-1:0]  kept_reg;

    logic [TIME_BITS-1:0]   start_reg;
    logic [TIME_BITS-1:0]   cend_reg;
    logic                   stop_reg;
    logic                   order_err_reg;
    status_t                status_reg;
    logic                   take_reg;
    logic                   up_reg;
    logic [TIME_BITS-1:0]   ee_reg;

    logic                   out_valid_reg;
    status_t                status_out_reg;
    logic                   keep_out_reg;
    logic [TIME_BITS-1:0]   emit_start_reg;
    logic [TIME_BITS-1:0]   emit_end_reg;
    logic                   stop_out_reg;
    logic [COUNT_BITS-1:0]  frames_seen_reg;
    logic [COUNT_BITS-1:0]  frames_kept_reg;
    logic [TIME_BITS-1:0]   export_reg;

    logic                   cfg_rate_wr;
    logic                   in_take;
    logic                   over_limit;
    logic                   take_now;
    logic                   up_now;
    logic [TIME_BITS-1:0]   span;
    status_t                status_now;
    logic                   need_div;
    logic                   div_start;
    logic [TIME_BITS-1:0]   div_dividend;
    logic [DIVISOR_BITS-1:0] div_divisor;
    logic                   div_done;
    logic [TIME_BITS-1:0]   div_quotient;
    logic [DIVISOR_BITS-1:0] div_remainder;
    logic [TIME_BITS-1:0]   period_numer;
    logic [DIVISOR_BITS-1:0] pad;
    logic [TIME_BITS:0]     sum_up;
    logic [TIME_BITS-1:0]   ee_up;
    logic [TIME_BITS-1:0]   ee_down;
    logic [TIME_BITS-1:0]   ee_now;
    logic                   keep_now;
    logic [TIME_BITS-1:0]   cursor_new;
    logic [TIME_BITS-1:0]   consumed_new;
    logic                   out_free;

    assign cfg_rate_wr = cfg_write && (cfg_index == CFG_FRAME_RATE);
    assign in_stall    = (state_reg != S_IDLE) || cfg_rate_wr;
    assign in_take     = in_valid && !in_stall;
    assign over_limit  = (limit_reg != '0) && (frame_end > limit_reg);
    assign out_free    = !out_valid_reg || !out_stall;

    always_comb
    begin
        take_now = (start_reg <= cursor_reg)
                   && ((start_reg == cend_reg) || (cursor_reg < cend_reg));
        up_now   = (cend_reg >= cursor_reg);
        span     = up_now ? (cend_reg - cursor_reg) : (cursor_reg - cend_reg);
        if (order_err_reg)
            status_now = STATUS_END_BEFORE_START;
        else if (start_reg != consumed_reg)
            status_now = STATUS_START_GAP;
        else
            status_now = STATUS_OK;
        need_div = (status_now == STATUS_OK) && take_now && (period_reg != '0);
    end

    // period = (2000 + rate) div (2 * rate)
    assign period_numer = {{(TIME_BITS-PERIOD_NUMER_BITS){1'b0}},
                           PERIOD_NUMER_BITS'(2 * MS_PER_SECOND)
                           + PERIOD_NUMER_BITS'(cfg_data[RATE_BITS-1:0])};

    always_comb
    begin
        div_start = cfg_rate_wr || ((state_reg == S_CHECK) && need_div);
        if (cfg_rate_wr)
        begin
            div_dividend = period_numer;
            div_divisor  = {cfg_data[RATE_BITS-1:0], 1'b0};
        end
        else
        begin
            div_dividend = span;
            div_divisor  = DIVISOR_BITS'(period_reg);
        end
    end

    frd_divider #(
        .DIVIDEND_W (TIME_BITS),
        .DIVISOR_W  (DIVISOR_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // rounding up to whole periods, or back by whole periods below the cursor
    always_comb
    begin
        pad     = (div_remainder != '0)
                  ? (DIVISOR_BITS'(period_reg) - div_remainder) : '0;
        sum_up  = {1'b0, cend_reg} + (TIME_BITS+1)'(pad);
        ee_up   = (sum_up > {1'b0, TIME_MAX}) ? TIME_MAX : sum_up[TIME_BITS-1:0];
        ee_down = cend_reg + TIME_BITS'(div_remainder);
        if (period_reg == '0)
            ee_now = cend_reg;
        else if (up_reg)
            ee_now = ee_up;
        else
            ee_now = ee_down;
    end

    always_comb
    begin
        keep_now     = (status_reg == STATUS_OK) && take_reg;
        cursor_new   = keep_now ? ee_reg : cursor_reg;
        consumed_new = (status_reg == STATUS_OK) ? cend_reg : consumed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= '0;
            limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_RATE:     rate_reg  <= cfg_data[RATE_BITS-1:0];
                CFG_DURATION_LIMIT: limit_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            period_reg      <= '0;
            cursor_reg      <= '0;
            consumed_reg    <= '0;
            seen_reg        <= '0;
            kept_reg        <= '0;
            start_reg       <= '0;
            cend_reg        <= '0;
            stop_reg        <= 1'b0;
            order_err_reg   <= 1'b0;
            status_reg      <= STATUS_OK;
            take_reg        <= 1'b0;
            up_reg          <= 1'b0;
            ee_reg          <= '0;
            out_valid_reg   <= 1'b0;
            status_out_reg  <= STATUS_OK;
            keep_out_reg    <= 1'b0;
            emit_start_reg  <= '0;
            emit_end_reg    <= '0;
            stop_out_reg    <= 1'b0;
            frames_seen_reg <= '0;
            frames_kept_reg <= '0;
            export_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    // a new rate restarts the period division
                    if (cfg_rate_wr)
                        state_reg <= S_PERIOD;
                    else if (in_take)
                    begin
                        start_reg     <= frame_start;
                        cend_reg      <= over_limit ? limit_reg : frame_end;
                        stop_reg      <= over_limit;
                        order_err_reg <= (frame_end < frame_start);
                        state_reg     <= S_CHECK;
                    end
                end
                S_PERIOD:
                begin
                    if (div_done && !cfg_rate_wr)
                    begin
                        period_reg <= (rate_reg == '0) ? '0 : div_quotient[PERIOD_BITS-1:0];
                        state_reg  <= S_IDLE;
                    end
                end
                S_CHECK:
                begin
                    status_reg <= status_now;
                    take_reg   <= take_now;
                    up_reg     <= up_now;
                    state_reg  <= need_div ? S_DIV : S_ALIGN;
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_ALIGN;
                end
                S_ALIGN:
                begin
                    ee_reg    <= ee_now;
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        seen_reg        <= seen_reg + COUNT_BITS'(1);
                        cursor_reg      <= cursor_new;
                        consumed_reg    <= consumed_new;
                        if (keep_now)
                            kept_reg <= kept_reg + COUNT_BITS'(1);
                        out_valid_reg   <= 1'b1;
                        status_out_reg  <= status_reg;
                        keep_out_reg    <= keep_now;
                        emit_start_reg  <= keep_now ? cursor_reg : '0;
                        emit_end_reg    <= keep_now ? ee_reg : '0;
                        stop_out_reg    <= (status_reg == STATUS_OK) && stop_reg;
                        frames_seen_reg <= seen_reg + COUNT_BITS'(1);
                        frames_kept_reg <= keep_now ? (kept_reg + COUNT_BITS'(1)) : kept_reg;
                        export_reg      <= (cursor_new > consumed_new) ? cursor_new
                                                                       : consumed_new;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_out_reg;
    assign keep            = keep_out_reg;
    assign emit_start      = emit_start_reg;
    assign emit_end        = emit_end_reg;
    assign stop            = stop_out_reg;
    assign frames_seen     = frames_seen_reg;
    assign frames_kept     = frames_kept_reg;
    assign export_duration = export_reg;

endmodule

>>> rtl/frd_checker.sv
`timescale 1ns / 1ps

module frd_checker #(
    parameter int TIME_BITS = frd_pkg::TIME_BITS_DEFAULT
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [frd_pkg::STATUS_BITS-1:0] status,
    input logic                            keep,
    input logic [TIME_BITS-1:0]            emit_start,
    input logic [TIME_BITS-1:0]            emit_end,
    input logic                            stop,
    input logic [frd_pkg::COUNT_BITS-1:0]  frames_seen
);

    import frd_pkg::*;

    logic [COUNT_BITS-1:0] seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (out_valid && !out_stall)
            seen_reg <= frames_seen;
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(keep)
            && $stable(emit_start) && $stable(emit_end) && $stable(frames_seen))
        else $error("result changed while stalled");

    // busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |->
            !keep && !stop && (emit_start == '0) && (emit_end == '0))
        else $error("error result carries frame data");

    // one result per transfer, in order
    a_seen_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> frames_seen == COUNT_BITS'(seen_reg + COUNT_BITS'(1)))
        else $error("frame count skipped");

endmodule

bind frame_rate_decimator_timing frd_checker #(.TIME_BITS(TIME_BITS)) u_frd_checker (.*);

>>> test/frame_timing_checker.sv
`timescale 1ns / 1ps

module frame_timing_checker #(
    parameter int TIME_BITS = frd_pkg::TIME_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [frd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]               cfg_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [TIME_BITS-1:0]               frame_start,
    input  logic [TIME_BITS-1:0]               frame_end,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [frd_pkg::STATUS_BITS-1:0]    status,
    input  logic                               keep,
    input  logic [TIME_BITS-1:0]               emit_start,
    input  logic [TIME_BITS-1:0]               emit_end,
    input  logic                               stop,
    input  logic [frd_pkg::COUNT_BITS-1:0]     frames_seen,
    input  logic [frd_pkg::COUNT_BITS-1:0]     frames_kept,
    input  logic [TIME_BITS-1:0]               export_duration,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 frame_total,
    output int                                 kept_total,
    output int                                 bad_timing_total,
    output int                                 clipped_total
);
    import frd_pkg::*;

    localparam longint unsigned TIME_TOP = (64'd1 << TIME_BITS) - 64'd1;

    typedef struct packed {
        status_t                 status;
        logic                    keep;
        logic [TIME_BITS-1:0]    emit_start;
        logic [TIME_BITS-1:0]    emit_end;
        logic                    stop;
        logic [COUNT_BITS-1:0]   seen;
        logic [COUNT_BITS-1:0]   kept;
        logic [TIME_BITS-1:0]    duration;
    } frame_verdict_t;

    frame_verdict_t       due_results [$];
    frame_verdict_t       want;
    logic [RATE_BITS-1:0] fps;
    logic [TIME_BITS-1:0] cap;
    logic [TIME_BITS-1:0] cursor;
    logic [TIME_BITS-1:0] consumed;
    logic [COUNT_BITS-1:0] seen_cnt;
    logic [COUNT_BITS-1:0] kept_cnt;

    function automatic longint unsigned period_ms(logic [RATE_BITS-1:0] r);
        if (r == '0)
            return 0;
        return (64'd2000 + r) / (64'd2 * r);
    endfunction

    function automatic longint unsigned snap_to_period(longint unsigned c, longint unsigned e,
                                                       longint unsigned per);
        longint unsigned span;
        longint unsigned steps;
        if (per == 0)
            return e;
        if (e >= c)
        begin
            span = e - c;
            steps = (span + per - 1) / per;
            span = steps * per;
            if (span > TIME_TOP - c)
                return TIME_TOP;
            return c + span;
        end
        steps = (c - e) / per;
        return c - steps * per;
    endfunction

    function automatic frame_verdict_t decide_frame(logic [TIME_BITS-1:0] s,
                                                    logic [TIME_BITS-1:0] e);
        frame_verdict_t       r;
        logic [TIME_BITS-1:0] stop_at;
        r = '0;
        r.status = STATUS_OK;
        seen_cnt = seen_cnt + 1'b1;
        if (e < s)
            r.status = STATUS_END_BEFORE_START;
        else if (s != consumed)
            r.status = STATUS_START_GAP;
        else
        begin
            stop_at = e;
            if (cap != '0 && e > cap)
            begin
                stop_at = cap;
                r.stop = 1'b1;
            end
            if (s <= cursor && (s == stop_at || cursor < stop_at))
            begin
                r.keep = 1'b1;
                r.emit_start = cursor;
                r.emit_end = TIME_BITS'(snap_to_period(cursor, stop_at, period_ms(fps)));
                kept_cnt = kept_cnt + 1'b1;
                cursor = r.emit_end;
            end
            consumed = stop_at;
        end
        r.seen = seen_cnt;
        r.kept = kept_cnt;
        r.duration = (cursor > consumed) ? cursor : consumed;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            fps = '0;
            cap = '0;
            cursor = '0;
            consumed = '0;
            seen_cnt = '0;
            kept_cnt = '0;
            fail_count = 0;
            pending = 0;
            frame_total = 0;
            kept_total = 0;
            bad_timing_total = 0;
            clipped_total = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_FRAME_RATE)
                    fps = cfg_data[RATE_BITS-1:0];
                else if (cfg_index == CFG_DURATION_LIMIT)
                    cap = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                want = decide_frame(frame_start, frame_end);
                due_results.push_back(want);
                frame_total++;
                kept_total += want.keep;
                clipped_total += want.stop;
                if (want.status != STATUS_OK)
                    bad_timing_total++;
            end
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer at %0t ns", $realtime);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status || keep !== want.keep
                        || emit_start !== want.emit_start || emit_end !== want.emit_end
                        || stop !== want.stop || frames_seen !== want.seen
                        || frames_kept !== want.kept || export_duration !== want.duration)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $write("mismatch on frame %0d (expected/actual): status %0d/%0d",
                                   want.seen, want.status, status);
                            $write(" keep %0d/%0d start %0d/%0d end %0d/%0d stop %0d/%0d",
                                   want.keep, keep, want.emit_start, emit_start,
                                   want.emit_end, emit_end, want.stop, stop);
                            $display(" seen %0d/%0d kept %0d/%0d duration %0d/%0d",
                                     want.seen, frames_seen, want.kept, frames_kept,
                                     want.duration, export_duration);
                        end
                    end
                end
            end
            pending = due_results.size();
        end
    end

endmodule

>>> test/frame_rate_decimator_timing_test.sv
`timescale 1ns / 1ps

module frame_rate_decimator_timing_test;
    import frd_pkg::*;

    localparam int TIME_BITS = TIME_BITS_DEFAULT;
    localparam logic [TIME_BITS-1:0] TIME_TOP = '1;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 14;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [TIME_BITS-1:0]       cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [TIME_BITS-1:0]       frame_start = '0;
    logic [TIME_BITS-1:0]       frame_end = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [STATUS_BITS-1:0]     status;
    logic                       keep;
    logic [TIME_BITS-1:0]       emit_start;
    logic [TIME_BITS-1:0]       emit_end;
    logic                       stop;
    logic [COUNT_BITS-1:0]      frames_seen;
    logic [COUNT_BITS-1:0]      frames_kept;
    logic [TIME_BITS-1:0]       export_duration;

    int fail_count;
    int pending;
    int frame_total;
    int kept_total;
    int bad_timing_total;
    int clipped_total;

    int sender_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_done = 0;
    int hold_left = 0;
    logic [TIME_BITS-1:0] timeline = '0;
    logic [TIME_BITS-1:0] cur_limit = '0;
    int unsigned rate_plan [PHASES] = '{30, 0, 1000, 1, 25, 333, 60, 24, 7, 1000, 0, 59, 30, 120};

    frame_rate_decimator_timing #(
        .TIME_BITS(TIME_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .frame_start(frame_start),
        .frame_end(frame_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .keep(keep),
        .emit_start(emit_start),
        .emit_end(emit_end),
        .stop(stop),
        .frames_seen(frames_seen),
        .frames_kept(frames_kept),
        .export_duration(export_duration)
    );

    frame_timing_checker #(
        .TIME_BITS(TIME_BITS)
    ) watch (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .frame_start(frame_start),
        .frame_end(frame_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .keep(keep),
        .emit_start(emit_start),
        .emit_end(emit_end),
        .stop(stop),
        .frames_seen(frames_seen),
        .frames_kept(frames_kept),
        .export_duration(export_duration),
        .fail_count(fail_count),
        .pending(pending),
        .frame_total(frame_total),
        .kept_total(kept_total),
        .bad_timing_total(bad_timing_total),
        .clipped_total(clipped_total)
    );

    always #2 clk = ~clk;

    // receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_done != hold_asked)
        begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_frame(input logic [TIME_BITS-1:0] s, input logic [TIME_BITS-1:0] e);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_start <= s;
        frame_end <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (e >= s && s == timeline)
            timeline = (cur_limit != '0 && e > cur_limit) ? cur_limit : e;
    endtask

    function automatic longint unsigned frame_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 0;
        if (roll < 70)
            return $urandom_range(1, 50);
        if (roll < 95)
            return $urandom_range(51, 1000);
        return $urandom_range(1001, 200000);
    endfunction

    task automatic random_frame();
        longint unsigned s;
        longint unsigned e;
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
        begin
            s = timeline;
            e = s + frame_length();
        end
        else if (pick < 85)
        begin
            if (timeline >= 5 && $urandom_range(1))
                s = timeline - $urandom_range(1, 5);
            else
                s = timeline + $urandom_range(1, 5);
            e = s + frame_length();
        end
        else if (pick < 93)
        begin
            e = timeline;
            s = e + $urandom_range(1, 300);
        end
        else
        begin
            s = $urandom & TIME_TOP;
            e = $urandom & TIME_TOP;
        end
        if (s > TIME_TOP)
            s = TIME_TOP;
        if (e > TIME_TOP)
            e = TIME_TOP;
        send_frame(TIME_BITS'(s), TIME_BITS'(e));
    endtask

    task automatic set_regs(input int unsigned fps, input logic [TIME_BITS-1:0] cap);
        cfg_write <= 1'b1;
        cfg_index <= CFG_DURATION_LIMIT;
        cfg_data <= cap;
        @(posedge clk);
        cfg_index <= CFG_FRAME_RATE;
        cfg_data <= TIME_BITS'(fps);
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_limit = cap;
    endtask

    // block must be empty before registers change
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TIME_BITS + 8) @(posedge clk);
    endtask

    initial
    begin
        logic [TIME_BITS-1:0] cap;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: input timing kept, no cap
        send_frame(0, 0);
        send_frame(0, 40);
        send_frame(40, 73);
        send_frame(TIME_TOP, 0);
        send_frame(TIME_TOP, TIME_TOP);
        send_frame(0, TIME_TOP);
        send_frame(74, 80);
        settle();

        set_regs(30, 0);
        send_frame(73, 100);
        send_frame(100, 105);
        send_frame(105, 105);
        send_frame(105, 140);
        send_frame(140, 180);
        send_frame(180, 300);
        send_frame(300, 310);
        send_frame(310, 305);
        settle();

        // cap clips the end, then a cap below the consumed time
        set_regs(1, 350);
        send_frame(310, 400);
        send_frame(350, 360);
        settle();
        set_regs(1000, 200);
        send_frame(350, 351);
        send_frame(200, 250);
        send_frame(200, 200);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            sender_idle_pct = (p < 5) ? 34 : (p < 10) ? 65 : 0;
            recv_idle_pct = (p < 5) ? 65 : (p < 10) ? 34 : 0;
            case (p % 5)
                1: cap = timeline + TIME_BITS'($urandom_range(500, 5000));
                2: cap = TIME_TOP;
                4: cap = (timeline > 300) ? timeline - TIME_BITS'($urandom_range(1, 300)) : '0;
                default: cap = '0;
            endcase
            set_regs(rate_plan[p], cap);
            if (p == 2 || p == 11)
                hold_asked = hold_asked + 1;
            repeat ((p % 5 == 4) ? 20 : 58) random_frame();
            settle();
        end

        // top of the time range, where the aligned end saturates
        set_regs(7, 0);
        send_frame(timeline, TIME_TOP - 1000);
        send_frame(TIME_TOP - 1000, TIME_TOP - 500);
        send_frame(TIME_TOP - 500, TIME_TOP - 3);
        send_frame(TIME_TOP - 3, TIME_TOP);
        send_frame(TIME_TOP, TIME_TOP);
        send_frame(TIME_TOP, 0);
        settle();

        $display("covered %0d frames over %0d register settings: %0d kept, %0d with bad timing,",
                 frame_total, PHASES + 5, kept_total, bad_timing_total);
        $display("%0d clipped by the duration cap, with stalls on both sides and long hold-offs",
                 clipped_total);
        if (fail_count == 0 && pending == 0)
            $display("frame_rate_decimator_timing_test passed");
        else
            $display("frame_rate_decimator_timing_test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("frame_rate_decimator_timing_test failed");
        $finish;
    end

endmodule
